/* src/bls_pkg.sv */
package bls_pkg;

    // Default coordinate width; the top level exposes it as COORD_BITS.
    localparam int COORD_BITS_DEF = 12;

    // Entries in the queue between the classifier and the stepper.
    localparam int QUEUE_DEPTH = 2;

    // Input word opcodes.
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // Control bits that travel with every queued word.
    typedef struct packed {
        logic mode;      // MODE_START or MODE_STEP
        logic x_down;    // x decreases along the line
        logic y_down;    // y decreases along the line
        logic last;      // start word whose endpoints coincide
    } t_ctl;

    localparam int CTL_BITS = $bits(t_ctl);

endpackage

/* src/bls_front.sv */
module bls_front #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
    parameter int ENTRY_BITS = bls_pkg::CTL_BITS + 7 * COORD_BITS + 2
) (
    input  logic                  i_mode,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_finish_x,
    input  logic [COORD_BITS-1:0] i_finish_y,
    output logic [ENTRY_BITS-1:0] o_entry
);
    import bls_pkg::*;

    localparam int EW = COORD_BITS + 2;

    t_ctl                  ctl;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [EW-1:0]         err;

    // Classify the word and precompute the line setup for start words.
    always_comb begin
        dx           = (i_start_x < i_finish_x) ? (i_finish_x - i_start_x)
                                                : (i_start_x - i_finish_x);
        dy           = (i_start_y < i_finish_y) ? (i_finish_y - i_start_y)
                                                : (i_start_y - i_finish_y);
        err          = {2'b00, dx} - {2'b00, dy};
        ctl.mode     = i_mode;
        ctl.x_down   = !(i_start_x < i_finish_x);
        ctl.y_down   = !(i_start_y < i_finish_y);
        ctl.last     = (i_start_x == i_finish_x) && (i_start_y == i_finish_y);
        o_entry      = {ctl, i_start_x, i_start_y, i_finish_x, i_finish_y, dx, dy, err};
    end

endmodule

/* src/bls_queue.sv */
module bls_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bls_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata,
    input  logic             i_pop
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

/* src/bls_back.sv */
module bls_back #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
    parameter int ENTRY_BITS = bls_pkg::CTL_BITS + 7 * COORD_BITS + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  logic [ENTRY_BITS-1:0] i_q_entry,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_pixel_valid,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_pixel_last
);
    import bls_pkg::*;

    localparam int EW = COORD_BITS + 2;

    // Unpacked queue head.
    t_ctl                  q_ctl;
    logic [COORD_BITS-1:0] q_sx, q_sy, q_fx, q_fy, q_dx, q_dy;
    logic [EW-1:0]         q_err;

    // Line state.
    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic [COORD_BITS-1:0] r_tgt_x, n_tgt_x;
    logic [COORD_BITS-1:0] r_tgt_y, n_tgt_y;
    logic [COORD_BITS-1:0] r_dx, n_dx;
    logic [COORD_BITS-1:0] r_dy, n_dy;
    logic                  r_x_down, n_x_down;
    logic                  r_y_down, n_y_down;
    logic [EW-1:0]         r_err, n_err;
    logic                  r_busy, n_busy;

    // Output register.
    logic                  r_out_valid;
    logic                  r_pix_valid, n_pix_valid;
    logic [COORD_BITS-1:0] r_pix_x, n_pix_x;
    logic [COORD_BITS-1:0] r_pix_y, n_pix_y;
    logic                  r_pix_last, n_pix_last;

    // Step arithmetic.
    logic signed [EW:0]    e2, dx_s, dy_s, err_s, err_sum;
    logic                  move_x, move_y;
    logic [COORD_BITS-1:0] step_x, step_y;

    assign {q_ctl, q_sx, q_sy, q_fx, q_fy, q_dx, q_dy, q_err} = i_q_entry;

    // Take the head whenever the output register is free or draining.
    assign o_q_pop = i_q_valid && (!r_out_valid || !i_stall);

    always_comb begin
        e2      = signed'({r_err, 1'b0});
        dx_s    = signed'({3'b000, r_dx});
        dy_s    = signed'({3'b000, r_dy});
        err_s   = signed'({r_err[EW-1], r_err});
        move_x  = e2 > -dy_s;
        move_y  = e2 < dx_s;
        err_sum = err_s - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
        step_x  = r_cur_x;
        step_y  = r_cur_y;
        if (move_x) begin
            step_x = r_x_down ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
        end
        if (move_y) begin
            step_y = r_y_down ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
        end
    end

    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_tgt_x     = r_tgt_x;
        n_tgt_y     = r_tgt_y;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_x_down    = r_x_down;
        n_y_down    = r_y_down;
        n_err       = r_err;
        n_busy      = r_busy;
        n_pix_valid = 1'b0;
        n_pix_x     = '0;
        n_pix_y     = '0;
        n_pix_last  = 1'b0;
        unique case (q_ctl.mode)
            MODE_START: begin
                n_cur_x     = q_sx;
                n_cur_y     = q_sy;
                n_tgt_x     = q_fx;
                n_tgt_y     = q_fy;
                n_dx        = q_dx;
                n_dy        = q_dy;
                n_x_down    = q_ctl.x_down;
                n_y_down    = q_ctl.y_down;
                n_err       = q_err;
                n_busy      = !q_ctl.last;
                n_pix_valid = 1'b1;
                n_pix_x     = q_sx;
                n_pix_y     = q_sy;
                n_pix_last  = q_ctl.last;
            end
            MODE_STEP: begin
                if (r_busy) begin
                    n_cur_x     = step_x;
                    n_cur_y     = step_y;
                    n_err       = err_sum[EW-1:0];
                    n_pix_valid = 1'b1;
                    n_pix_x     = step_x;
                    n_pix_y     = step_y;
                    n_pix_last  = (step_x == r_tgt_x) && (step_y == r_tgt_y);
                    n_busy      = !n_pix_last;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy      <= n_busy;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_tgt_x     <= n_tgt_x;
            r_tgt_y     <= n_tgt_y;
            r_dx        <= n_dx;
            r_dy        <= n_dy;
            r_x_down    <= n_x_down;
            r_y_down    <= n_y_down;
            r_err       <= n_err;
            r_pix_valid <= n_pix_valid;
            r_pix_x     <= n_pix_x;
            r_pix_y     <= n_pix_y;
            r_pix_last  <= n_pix_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_valid = r_pix_valid;
    assign o_pixel_x     = r_pix_x;
    assign o_pixel_y     = r_pix_y;
    assign o_pixel_last  = r_pix_last;

endmodule

/* src/bresenham_line_stepper_core.sv */
// Path: an accepted word is written into the queue, and the stepper then registers
//   its result word in its output register.
// Throughput: one word per cycle unless the result side stalls (combinational step).
// Reset: synchronous, active low; empties the queue, drops the output word
//   and leaves the stepper idle.
module bresenham_line_stepper_core #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_mode,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_finish_x,
    input  logic [COORD_BITS-1:0] i_finish_y,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_pixel_valid,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_pixel_last
);
    import bls_pkg::*;

    // Queue word: control bits, both endpoints, |dx|, |dy| and the initial error.
    localparam int ENTRY_BITS = CTL_BITS + 7 * COORD_BITS + 2;

    logic [ENTRY_BITS-1:0] front_entry;
    logic [ENTRY_BITS-1:0] q_entry;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic                  push;

    // Accept a word whenever the queue has room; the stepper drains it
    // every cycle that its output register can move, so the queue only
    // fills when the result side stalls.
    assign o_stall = q_full;
    assign push    = i_valid && !q_full;

    // Front: classify the word and compute the line setup.
    bls_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_front (
        .i_mode     (i_mode),
        .i_start_x  (i_start_x),
        .i_start_y  (i_start_y),
        .i_finish_x (i_finish_x),
        .i_finish_y (i_finish_y),
        .o_entry    (front_entry)
    );

    // Short queue decoupling the input side from the stepper.
    bls_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (q_entry),
        .i_pop   (q_pop)
    );

    // Back: hold the line state, advance one pixel per step word while a line is
    // in progress and register the result word.
    bls_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_entry),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_valid (o_pixel_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_last  (o_pixel_last)
    );

endmodule

/* src/bls_checker.sv */
module bls_props #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  i_mode,
    input logic [COORD_BITS-1:0] i_start_x,
    input logic [COORD_BITS-1:0] i_start_y,
    input logic [COORD_BITS-1:0] i_finish_x,
    input logic [COORD_BITS-1:0] i_finish_y,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic                  o_pixel_valid,
    input logic [COORD_BITS-1:0] o_pixel_x,
    input logic [COORD_BITS-1:0] o_pixel_y,
    input logic                  o_pixel_last
);
    // Drop any pending result word on reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word survives reset");

    // Hold a stalled result word.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_valid) && $stable(o_pixel_x)
                               && $stable(o_pixel_y) && $stable(o_pixel_last))
        else $error("stalled result word changed");

    // An idle step reports zeros.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pixel_valid |-> o_pixel_x == '0 && o_pixel_y == '0 && !o_pixel_last)
        else $error("idle step result not zero");

    // Flag the end point only on a real pixel.
    a_last_has_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pixel_last |-> o_pixel_valid)
        else $error("last flag without a pixel");

endmodule

bind bresenham_line_stepper_core bls_props #(.COORD_BITS(COORD_BITS)) u_bls_props (.*);
